FILE: rtl/kstd_pkg.sv
// kstd_pkg: shared types and constants for the keyed slot table with decay
// no dependencies
package kstd_pkg;
	localparam int SlotCount = 32;
	localparam int SlotW     = 5;
	localparam int CountW    = 6;
	localparam int KeyW      = 16;
	localparam int TimeW     = 32;
	localparam int RadW      = 16;
	localparam int FrameW    = 10;
	localparam int GraceMs   = 32;

	// floor(x / 1000) for x below 2^26 as (x * LossRecip) >> LossShift
	localparam int              LossShift = 36;
	localparam int              RecipW    = 27;
	localparam int              FrameRecW = 37;
	localparam logic [26:0]     LossRecip = 27'd68719477;

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	localparam logic [1:0] HOW_KEY   = 2'd0;
	localparam logic [1:0] HOW_EXP   = 2'd1;
	localparam logic [1:0] HOW_FALLB = 2'd2;

	// one slot as it travels along the chain
	typedef struct packed {
		logic [KeyW-1:0]  key;
		logic [TimeW-1:0] expiry;
		logic [RadW-1:0]  radius;
		logic [RadW-1:0]  decay;
	} slot_t;

	// command broadcast to every cell during one pass
	typedef struct packed {
		logic             shift;
		logic             clear;
	} cell_ctl_t;
endpackage

FILE: rtl/kstd_cell.sv
// kstd_cell: one slot register of the circulating chain
// depends on kstd_pkg
module kstd_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  kstd_pkg::cell_ctl_t ctl,
	input  kstd_pkg::slot_t     din,
	output kstd_pkg::slot_t     dout
);
	kstd_pkg::slot_t slot_q;

	// pass the neighbour's slot on each shift; clear zeroes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctl.clear) begin
			slot_q <= '0;
		end else if (ctl.shift) begin
			slot_q <= din;
		end
	end

	assign dout = slot_q;
endmodule

FILE: rtl/kstd_proc.sv
// kstd_proc: per-slot work at the head of the chain (match, expiry, decay)
// depends on kstd_pkg
module kstd_proc (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    step,
	input  logic [1:0]              mode,
	input  logic [kstd_pkg::KeyW-1:0]  key,
	input  logic [kstd_pkg::TimeW-1:0] now_ms,
	input  logic [kstd_pkg::FrameW-1:0] frame_ms,
	input  logic [kstd_pkg::SlotW-1:0] idx,
	input  kstd_pkg::slot_t         din,
	output kstd_pkg::slot_t         dout,
	output logic                    key_hit_q,
	output logic                    exp_hit_q,
	output logic [kstd_pkg::SlotW-1:0] key_slot_q,
	output logic [kstd_pkg::SlotW-1:0] exp_slot_q
);
	logic [kstd_pkg::TimeW-1:0]     limit;
	logic [kstd_pkg::FrameRecW-1:0] fm_q;
	logic [52:0]                    prod;
	logic [16:0]                    loss;
	logic                           live;

	assign limit = (now_ms >= kstd_pkg::TimeW'(kstd_pkg::GraceMs))
		? now_ms - kstd_pkg::TimeW'(kstd_pkg::GraceMs) : '0;
	// frame time already scaled by the reciprocal of 1000, one multiply per slot
	assign prod  = 53'(din.decay) * 53'(fm_q);
	assign loss  = prod[52:kstd_pkg::LossShift];
	assign live  = din.radius != '0;

	// tick rewrites the radius as the slot passes; other modes pass it on
	always_comb begin
		dout = din;
		if (mode == kstd_pkg::MODE_TICK && live) begin
			if (din.expiry < limit || loss >= {1'b0, din.radius}) begin
				dout.radius = '0;
			end else begin
				dout.radius = din.radius - loss[kstd_pkg::RadW-1:0];
			end
		end
	end

	// first key match and first expired slot seen during the pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hit_q  <= 1'b0;
			exp_hit_q  <= 1'b0;
			key_slot_q <= '0;
			exp_slot_q <= '0;
			fm_q       <= '0;
		end else if (start) begin
			key_hit_q <= 1'b0;
			exp_hit_q <= 1'b0;
			fm_q      <= kstd_pkg::FrameRecW'(frame_ms) *
				kstd_pkg::FrameRecW'(kstd_pkg::LossRecip);
		end else if (step) begin
			if (!key_hit_q && key != '0 && din.key == key) begin
				key_hit_q  <= 1'b1;
				key_slot_q <= idx;
			end
			if (!exp_hit_q && din.expiry < now_ms) begin
				exp_hit_q  <= 1'b1;
				exp_slot_q <= idx;
			end
		end
	end
endmodule

FILE: rtl/keyed_slot_table_with_decay_unit.sv
// keyed_slot_table_with_decay_unit: top level, chain of slot cells and sequencer
// depends on kstd_pkg, kstd_cell, kstd_proc
//
// channel  dir  fields (lsb first)
// s_axis   in   tdata: mode key now_ms expire_ms start_radius decay_rate frame_ms
// m_axis   out  tdata: slot how_found live_count
//
// allocate: result posted after a search pass and a write pass over all slots,
// then the done state; tick, clear and unused mode 3: one pass over all slots,
// then the done state. the slot at the head passes the shared match/decay unit
// once per cycle. input ready returns the cycle after the result transfer, so a
// new item is taken only once the last result has gone.
// reset clears the table; a held result stalls the next item until taken.
module keyed_slot_table_with_decay_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // mode, key, now_ms, expire_ms, start_radius, decay_rate, frame_ms
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [15:0]  m_axis_tdata   // slot, how_found, live_count
);
	localparam int N = kstd_pkg::SlotCount;

	typedef enum logic [2:0] {ST_IDLE, ST_SEARCH, ST_WRITE, ST_TICK, ST_DONE} state_t;

	state_t                         state_q;
	logic [1:0]                     mode_q;
	logic [kstd_pkg::KeyW-1:0]      key_q;
	logic [kstd_pkg::TimeW-1:0]     now_q, exp_q;
	logic [kstd_pkg::RadW-1:0]      rad_q, dec_q;
	logic [kstd_pkg::SlotW:0]       cnt_q;
	logic [kstd_pkg::SlotW-1:0]     sel_q;
	logic [1:0]                     how_q;
	logic [kstd_pkg::CountW-1:0]    live_q;
	logic                           busy_q;

	kstd_pkg::slot_t   chain [N];
	kstd_pkg::slot_t   head_in, proc_out;
	kstd_pkg::cell_ctl_t ctl;
	logic key_hit, exp_hit;
	logic [kstd_pkg::SlotW-1:0] key_slot, exp_slot, idx;
	logic accept, step, start;
	kstd_pkg::slot_t wr_slot;
	logic [kstd_pkg::SlotW-1:0] wsel;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy_q && !m_axis_tvalid;
	assign idx = cnt_q[kstd_pkg::SlotW-1:0];
	assign step = state_q == ST_SEARCH;
	assign start = accept;
	assign ctl.shift = state_q == ST_SEARCH || state_q == ST_WRITE || state_q == ST_TICK;
	assign ctl.clear = accept && s_axis_tdata[1:0] == kstd_pkg::MODE_CLEAR;

	// the selected slot is written as it enters the tail in the write pass; key match wins, then expiry, else slot 0
	always_comb begin
		wsel = key_hit ? key_slot : (exp_hit ? exp_slot : '0);
		wr_slot = '{key_q, exp_q, rad_q, dec_q};
	end

	// cell 0 is the head; slot i sits at cell 0 after i shifts
	assign head_in = chain[0];

	kstd_proc u_proc (
		.clk, .arst_n, .start, .step, .mode(mode_q), .key(key_q), .now_ms(now_q),
		.frame_ms(s_axis_tdata[123:114]), .idx, .din(head_in), .dout(proc_out),
		.key_hit_q(key_hit), .exp_hit_q(exp_hit),
		.key_slot_q(key_slot), .exp_slot_q(exp_slot)
	);

	// ring: head output goes to the tail, others move towards the head
	for (genvar g = 0; g < N; g++) begin : g_cell
		kstd_pkg::slot_t d;
		always_comb begin
			if (g == N-1) begin
				d = proc_out;
				if (state_q == ST_WRITE && idx == wsel) begin
					d = wr_slot;
				end
			end else begin
				d = chain[g+1];
			end
		end
		kstd_cell u_cell (.clk, .arst_n, .ctl, .din(d), .dout(chain[g]));
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
			cnt_q <= '0;
			live_q <= '0;
			how_q <= '0;
			sel_q <= '0;
			mode_q <= '0;
			key_q <= '0;
			now_q <= '0;
			exp_q <= '0;
			rad_q <= '0;
			dec_q <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q  <= s_axis_tdata[1:0];
						key_q   <= s_axis_tdata[17:2];
						now_q   <= s_axis_tdata[49:18];
						exp_q   <= s_axis_tdata[81:50];
						rad_q   <= s_axis_tdata[97:82];
						dec_q   <= s_axis_tdata[113:98];
						busy_q  <= 1'b1;
						cnt_q   <= '0;
						live_q  <= '0;
						how_q   <= '0;
						sel_q   <= '0;
						state_q <= (s_axis_tdata[1:0] == kstd_pkg::MODE_ALLOC) ? ST_SEARCH :
							ST_TICK;
					end
				end
				ST_SEARCH: begin
					if (cnt_q == (kstd_pkg::SlotW+1)'(N-1)) begin
						cnt_q <= '0;
						state_q <= ST_WRITE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WRITE: begin
					if (cnt_q == '0) begin
						if (key_hit) begin
							sel_q <= key_slot; how_q <= kstd_pkg::HOW_KEY;
						end else if (exp_hit) begin
							sel_q <= exp_slot; how_q <= kstd_pkg::HOW_EXP;
						end else begin
							sel_q <= '0; how_q <= kstd_pkg::HOW_FALLB;
						end
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (kstd_pkg::SlotW+1)'(N-1)) state_q <= ST_DONE;
				end
				ST_TICK: begin
					if (proc_out.radius != '0) live_q <= live_q + 1'b1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (kstd_pkg::SlotW+1)'(N-1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					busy_q <= 1'b0;
					m_axis_tvalid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// live count during the write pass, using the slot as it enters the tail
	logic [kstd_pkg::CountW-1:0] wlive_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlive_q <= '0;
		end else if (accept) begin
			wlive_q <= '0;
		end else if (state_q == ST_WRITE) begin
			if ((idx == wsel ? wr_slot.radius : proc_out.radius) != '0)
				wlive_q <= wlive_q + 1'b1;
		end
	end

	assign m_axis_tdata = {3'b0, (mode_q == kstd_pkg::MODE_ALLOC) ? wlive_q : live_q,
		how_q, sel_q};

	ap_one_pass: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q) else $error("busy not raised");
	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_axis_tready) else $error("accept while busy");
	ap_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> m_axis_tvalid) else $error("no result");
endmodule
